// ----- design/nsbt_pkg.sv -----
// nsbt_pkg: shared constants and types for the neighbour sync backoff table
// used by every module of the block, no dependencies
package nsbt_pkg;
	localparam int unsigned NEIGHBOURS_DEF = 32;
	localparam int unsigned ADDR_W = 48;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned TICK_W = 20;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [1:0] FUNC_LISTED = 2'd0;
	localparam logic [1:0] FUNC_ROUND_END = 2'd1;
	localparam logic [1:0] FUNC_EMPTY = 2'd2;
	localparam logic [1:0] FUNC_BEACON = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_COOLOFF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEER_WAIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEND_WIFI = 2'd2;

	localparam logic [2:0] DEC_NONE = 3'd0;
	localparam logic [2:0] DEC_COOLOFF = 3'd1;
	localparam logic [2:0] DEC_OWN_BACKOFF = 3'd2;
	localparam logic [2:0] DEC_PEER = 3'd3;
	localparam logic [2:0] DEC_SYNC_BACKOFF = 3'd4;
	localparam logic [2:0] DEC_SYNC_PEER = 3'd5;
	localparam logic [2:0] DEC_BACKOFF_START = 3'd6;

	// one neighbour entry as it circulates through the chain
	typedef struct packed {
		logic valid;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] cooloff_end;
		logic backoff_on;
		logic [TIME_W-1:0] backoff_end;
		logic peer_syncing;
		logic [TIME_W-1:0] peer_sync_end;
		logic seen;
	} entry_t;

	// per-pass command from the controller to every cell of the ring
	typedef struct packed {
		logic rotate;
		logic clear_all;
	} chain_ctl_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TICK_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {{(TIME_W-TICK_W+1){1'b0}}, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction
endpackage

// ----- design/neighbour_sync_backoff_table_unit.sv -----
// neighbour_sync_backoff_table_unit: top level with control and two cell rings
// depends on nsbt_pkg, nsbt_ring
//
// Input word: func, radio, neighbour_address, now_ticks, backoff_draw, taken
// when in_valid is high and in_stall is low. Output word: send_beacon,
// beacon_destination, decision, table_full, held while out_stall is high.
// Each pass rotates the selected ring once around.
// Listed or beacon words rotate twice (search, then update); sweeps and
// table-full words rotate once. One word is in work at a time;
// the next word is taken once the result is in the output register, even
// while the receiver stalls it, and the block waits only if that register
// is still full when a new result is ready.
// Reset clears all valid marks, the changed flags and the registers to
// their defaults. Configuration writes are taken at any time.
module neighbour_sync_backoff_table_unit import nsbt_pkg::*; #(
	parameter int unsigned NEIGHBOURS = NEIGHBOURS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] func,
	input logic radio,
	input logic [ADDR_W-1:0] neighbour_address,
	input logic [TIME_W-1:0] now_ticks,
	input logic [TICK_W-1:0] backoff_draw,
	output logic out_valid,
	input logic out_stall,
	output logic send_beacon,
	output logic [ADDR_W-1:0] beacon_destination,
	output logic [2:0] decision,
	output logic table_full,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [TICK_W-1:0] cfg_data
);
	localparam int unsigned CNT_W = $clog2(NEIGHBOURS);

	typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_UPDATE, ST_DONE} state_t;
	state_t state_q;

	logic [TICK_W-1:0] cooloff_q, peer_wait_q;
	logic send_wifi_q;
	logic [1:0] changed_q;
	logic [1:0] func_q;
	logic radio_q;
	logic [ADDR_W-1:0] addr_q;
	logic [TIME_W-1:0] now_q;
	logic [TICK_W-1:0] draw_q;
	logic [CNT_W-1:0] cnt_q;
	logic found_q, free_q, sweep_q;
	logic [CNT_W-1:0] slot_q;
	logic [2:0] dec_q;
	logic send_q;

	entry_t tail [2];
	entry_t head [2];
	chain_ctl_t ctl [2];
	entry_t cur, ent, upd;
	logic [2:0] dec_next;
	logic rot, hit, last, upd_here, beacon_radio;

	assign cur = tail[radio_q];
	assign rot = (state_q == ST_SEARCH) || (state_q == ST_UPDATE);
	assign last = (cnt_q == CNT_W'(NEIGHBOURS - 1));
	assign hit = cur.valid && (cur.addr == addr_q);
	assign upd_here = (slot_q == cnt_q);
	assign beacon_radio = (radio_q == 1'b0) ? send_wifi_q : !send_wifi_q;

	// entry at the chosen slot, fresh when the neighbour is new
	always_comb begin
		ent = cur;
		if (!found_q) begin
			ent.valid = 1'b1;
			ent.addr = addr_q;
			ent.cooloff_end = '0;
			ent.backoff_on = 1'b0;
			ent.backoff_end = '0;
			ent.peer_syncing = 1'b0;
			ent.peer_sync_end = '0;
			ent.seen = 1'b0;
		end
	end

	always_comb begin
		if (ent.cooloff_end >= now_q) dec_next = DEC_COOLOFF;
		else if (ent.backoff_on && ent.backoff_end >= now_q) dec_next = DEC_OWN_BACKOFF;
		else if (ent.peer_syncing && ent.peer_sync_end >= now_q) dec_next = DEC_PEER;
		else if (ent.backoff_on) dec_next = DEC_SYNC_BACKOFF;
		else if (ent.peer_syncing) dec_next = DEC_SYNC_PEER;
		else dec_next = DEC_BACKOFF_START;
	end

	always_comb begin
		upd = cur;
		if (state_q == ST_SEARCH && sweep_q && cur.valid) begin
			if (func_q == FUNC_EMPTY || !cur.seen) begin
				upd.backoff_on = 1'b0;
				upd.backoff_end = '0;
				upd.peer_syncing = 1'b0;
				upd.peer_sync_end = '0;
			end
			upd.seen = 1'b0;
		end
		if (state_q == ST_UPDATE && upd_here) begin
			upd = ent;
			if (func_q == FUNC_BEACON) begin
				upd.backoff_on = 1'b0;
				upd.backoff_end = '0;
				upd.peer_syncing = 1'b1;
				upd.peer_sync_end = sat_add(now_q, peer_wait_q);
			end else begin
				upd.seen = 1'b1;
				case (dec_next) inside
					DEC_SYNC_BACKOFF, DEC_SYNC_PEER: begin
						upd.cooloff_end = sat_add(now_q, cooloff_q);
						upd.backoff_on = 1'b0;
						upd.backoff_end = '0;
						upd.peer_syncing = 1'b0;
						upd.peer_sync_end = '0;
					end
					DEC_BACKOFF_START: begin
						upd.backoff_on = 1'b1;
						upd.backoff_end = sat_add(now_q, draw_q);
					end
					default: ;
				endcase
			end
		end
	end

	for (genvar r = 0; r < 2; r++) begin : g_radio
		assign ctl[r].rotate = rot && (radio_q == 1'(r));
		assign ctl[r].clear_all = 1'b0;
		assign head[r] = (radio_q == 1'(r)) ? upd : tail[r];
		nsbt_ring #(.NEIGHBOURS(NEIGHBOURS)) u_ring (
			.clk(clk), .arst_n(arst_n), .ctl(ctl[r]), .head_in(head[r]),
			.tail_out(tail[r])
		);
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooloff_q <= TICK_W'(300);
			peer_wait_q <= TICK_W'(100);
			send_wifi_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COOLOFF: cooloff_q <= cfg_data;
				REG_PEER_WAIT: peer_wait_q <= cfg_data;
				REG_SEND_WIFI: send_wifi_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			changed_q <= '0;
			cnt_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			sweep_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != ST_DONE) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						radio_q <= radio;
						addr_q <= neighbour_address;
						now_q <= now_ticks;
						draw_q <= backoff_draw;
						cnt_q <= '0;
						found_q <= 1'b0;
						free_q <= 1'b0;
						send_q <= 1'b0;
						dec_q <= DEC_NONE;
						sweep_q <= (func == FUNC_ROUND_END) ||
							(func == FUNC_EMPTY && changed_q[radio]);
						if (func == FUNC_ROUND_END) changed_q[radio] <= 1'b1;
						if (func == FUNC_EMPTY) changed_q[radio] <= 1'b0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (func_q == FUNC_LISTED || func_q == FUNC_BEACON) begin
						if (hit && !found_q) begin
							found_q <= 1'b1;
							slot_q <= cnt_q;
						end else if (!cur.valid && !free_q && !found_q) begin
							free_q <= 1'b1;
							slot_q <= cnt_q;
						end
					end
					cnt_q <= last ? '0 : cnt_q + 1'b1;
					if (last) begin
						if ((func_q == FUNC_LISTED || func_q == FUNC_BEACON) &&
								(found_q || hit || free_q || !cur.valid)) begin
							state_q <= ST_UPDATE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_UPDATE: begin
					if (upd_here) begin
						if (func_q == FUNC_BEACON) begin
							changed_q[radio_q] <= 1'b1;
						end else begin
							dec_q <= dec_next;
							send_q <= (dec_next == DEC_SYNC_BACKOFF ||
								dec_next == DEC_SYNC_PEER) && beacon_radio;
						end
					end
					cnt_q <= last ? '0 : cnt_q + 1'b1;
					if (last) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						send_beacon <= send_q;
						beacon_destination <= send_q ? addr_q : '0;
						decision <= dec_q;
						table_full <= (func_q == FUNC_LISTED || func_q == FUNC_BEACON) &&
							!found_q && !free_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- design/nsbt_cell.sv -----
// nsbt_cell: one storage cell of the neighbour ring
// depends on nsbt_pkg
module nsbt_cell import nsbt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic shift,
	input logic clear_all,
	input entry_t din,
	output entry_t dout
);
	logic valid_q;
	entry_t e_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear_all) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= din.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (shift) begin
			e_q <= din;
		end
	end
	always_comb begin
		dout = e_q;
		dout.valid = valid_q;
	end
endmodule

// ----- design/nsbt_ring.sv -----
// nsbt_ring: ring of cells holding one radio's table, rotated one slot a cycle
// while ctl.rotate is set; depends on nsbt_pkg and nsbt_cell
module nsbt_ring import nsbt_pkg::*; #(
	parameter int unsigned NEIGHBOURS = NEIGHBOURS_DEF
) (
	input logic clk,
	input logic arst_n,
	input chain_ctl_t ctl,
	input entry_t head_in,
	output entry_t tail_out
);
	entry_t link [NEIGHBOURS+1];
	assign link[0] = head_in;
	for (genvar i = 0; i < NEIGHBOURS; i++) begin : g_cell
		nsbt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .shift(ctl.rotate), .clear_all(ctl.clear_all),
			.din(link[i]), .dout(link[i+1])
		);
	end
	assign tail_out = link[NEIGHBOURS];
endmodule

// ----- tb/tb.sv -----
// tb: self-checking testbench for neighbour_sync_backoff_table_unit
// depends on nsbt_pkg and the block's rtl; predicts every output word in-line
`timescale 1ns / 1ps

module tb;
	import nsbt_pkg::*;

	localparam int NB = NEIGHBOURS_DEF;
	localparam int SLOTS = 2 * NB;
	localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};

	typedef struct packed {
		logic send;
		logic [ADDR_W-1:0] dest;
		logic [2:0] dec;
		logic full;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = FUNC_LISTED;
	logic radio = 1'b0;
	logic [ADDR_W-1:0] neighbour_address = '0;
	logic [TIME_W-1:0] now_ticks = '0;
	logic [TICK_W-1:0] backoff_draw = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic send_beacon;
	logic [ADDR_W-1:0] beacon_destination;
	logic [2:0] decision;
	logic table_full;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_COOLOFF;
	logic [TICK_W-1:0] cfg_data = '0;

	neighbour_sync_backoff_table_unit u_dut (.*);

	// predictor state
	logic [TICK_W-1:0] m_cooloff, m_peer_wait;
	logic m_send_wifi;
	logic m_valid [SLOTS];
	logic [ADDR_W-1:0] m_addr [SLOTS];
	logic [TIME_W-1:0] m_cool_end [SLOTS], m_bo_end [SLOTS], m_ps_end [SLOTS];
	logic m_bo_on [SLOTS], m_ps_on [SLOTS], m_seen [SLOTS];
	logic m_changed [2];

	verdict_t pending_verdicts [$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int syncs_seen = 0;
	int fulls_seen = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_off = 1'b0;
	logic [TIME_W-1:0] clock_now = 32'd1000;

	initial forever #1 clk = ~clk;

	initial begin
		#20_000_000;
		$display("** neighbour_sync_backoff_table_unit: FAILED **");
		$finish;
	end

	function automatic logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [TICK_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + b;
		return s[TIME_W] ? T_MAX : s[TIME_W-1:0];
	endfunction

	task automatic clear_timers(int k);
		m_bo_on[k] = 1'b0;
		m_bo_end[k] = '0;
		m_ps_on[k] = 1'b0;
		m_ps_end[k] = '0;
	endtask

	task automatic locate_slot(logic r, logic [ADDR_W-1:0] a, output int k);
		int freek;
		freek = -1;
		k = -1;
		for (int i = 0; i < NB; i++) begin
			if (m_valid[r*NB+i]) begin
				if (k < 0 && m_addr[r*NB+i] == a) k = r*NB+i;
			end else if (freek < 0) begin
				freek = r*NB+i;
			end
		end
		if (k < 0 && freek >= 0) begin
			k = freek;
			m_valid[k] = 1'b1;
			m_addr[k] = a;
			m_cool_end[k] = '0;
			clear_timers(k);
			m_seen[k] = 1'b0;
		end
	endtask

	task automatic predict_verdict(logic [1:0] f, logic r, logic [ADDR_W-1:0] a,
			logic [TIME_W-1:0] now, logic [TICK_W-1:0] draw);
		verdict_t v;
		int k;
		logic sync;
		v = '0;
		sync = 1'b0;
		case (f)
			FUNC_LISTED: begin
				locate_slot(r, a, k);
				if (k < 0) begin
					v.full = 1'b1;
				end else begin
					m_seen[k] = 1'b1;
					if (m_cool_end[k] >= now) v.dec = DEC_COOLOFF;
					else if (m_bo_on[k] && m_bo_end[k] >= now) v.dec = DEC_OWN_BACKOFF;
					else if (m_ps_on[k] && m_ps_end[k] >= now) v.dec = DEC_PEER;
					else if (m_bo_on[k]) begin
						v.dec = DEC_SYNC_BACKOFF;
						sync = 1'b1;
					end else if (m_ps_on[k]) begin
						v.dec = DEC_SYNC_PEER;
						sync = 1'b1;
					end else begin
						v.dec = DEC_BACKOFF_START;
						m_bo_on[k] = 1'b1;
						m_bo_end[k] = add_sat(now, draw);
					end
					if (sync) begin
						m_cool_end[k] = add_sat(now, m_cooloff);
						clear_timers(k);
						if (r == ~m_send_wifi) begin
							v.send = 1'b1;
							v.dest = a;
						end
					end
				end
			end
			FUNC_ROUND_END: begin
				for (int i = 0; i < NB; i++) begin
					if (m_valid[r*NB+i]) begin
						if (!m_seen[r*NB+i]) clear_timers(r*NB+i);
						m_seen[r*NB+i] = 1'b0;
					end
				end
				m_changed[r] = 1'b1;
			end
			FUNC_EMPTY: begin
				if (m_changed[r]) begin
					for (int i = 0; i < NB; i++) begin
						if (m_valid[r*NB+i]) begin
							clear_timers(r*NB+i);
							m_seen[r*NB+i] = 1'b0;
						end
					end
					m_changed[r] = 1'b0;
				end
			end
			default: begin
				locate_slot(r, a, k);
				if (k < 0) begin
					v.full = 1'b1;
				end else begin
					m_bo_on[k] = 1'b0;
					m_bo_end[k] = '0;
					m_ps_on[k] = 1'b1;
					m_ps_end[k] = add_sat(now, m_peer_wait);
					m_changed[r] = 1'b1;
				end
			end
		endcase
		pending_verdicts.insert(pending_verdicts.size(), v);
	endtask

	task automatic send_word(logic [1:0] f, logic r, logic [ADDR_W-1:0] a,
			logic [TIME_W-1:0] now, logic [TICK_W-1:0] draw);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk);
		func <= f;
		radio <= r;
		neighbour_address <= a;
		now_ticks <= now;
		backoff_draw <= draw;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_verdict(f, r, a, now, draw);
		words_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (4 * NB + 10) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_COOLOFF: m_cooloff = val;
			REG_PEER_WAIT: m_peer_wait = val;
			default: m_send_wifi = val[0];
		endcase
	endtask

	// receiver side
	always @(negedge clk) begin
		out_stall <= hold_off || (stall_pct > 0 && $urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && out_valid && !out_stall) begin
			words_checked++;
			if (pending_verdicts.size() == 0) begin
				$error("unexpected output word");
				errors++;
			end else begin
				v = pending_verdicts.pop_front();
				if (send_beacon != v.send) begin
					$error("send_beacon exp %0d got %0d", v.send, send_beacon);
					errors++;
				end
				if (beacon_destination != v.dest) begin
					$error("beacon_destination exp %h got %h", v.dest, beacon_destination);
					errors++;
				end
				if (decision != v.dec) begin
					$error("decision exp %0d got %0d", v.dec, decision);
					errors++;
				end
				if (table_full != v.full) begin
					$error("table_full exp %0d got %0d", v.full, table_full);
					errors++;
				end
				if (v.send) syncs_seen++;
				if (v.full) fulls_seen++;
			end
		end
	end

	task automatic test_directed;
		logic [TIME_W-1:0] t;
		t = 32'd50;
		// first contact starts a backoff, then wait, then sync after backoff, then cooloff, then a new backoff
		send_word(FUNC_LISTED, 1'b0, 48'h0, t, 20'd1);
		send_word(FUNC_LISTED, 1'b0, 48'h0, t + 1, 20'd1);
		send_word(FUNC_LISTED, 1'b0, 48'h0, t + 2, 20'd1);
		send_word(FUNC_LISTED, 1'b0, 48'h0, t + 100, 20'd1);
		send_word(FUNC_LISTED, 1'b0, 48'h0, t + 400, 20'd1);
		// beacon then peer wait, sync after peer on radio 1 (no beacon sent)
		send_word(FUNC_BEACON, 1'b1, {ADDR_W{1'b1}}, t, 20'hFFFFF);
		send_word(FUNC_LISTED, 1'b1, {ADDR_W{1'b1}}, t + 50, 20'hFFFFF);
		send_word(FUNC_LISTED, 1'b1, {ADDR_W{1'b1}}, t + 200, 20'hFFFFF);
		// saturation near the top of time, zero draw
		send_word(FUNC_LISTED, 1'b0, 48'h123456789ABC, T_MAX - 5, 20'hFFFFF);
		send_word(FUNC_LISTED, 1'b0, 48'h55AA55AA55AA, 32'd3, 20'd0);
		send_word(FUNC_BEACON, 1'b0, 48'h123456789ABC, T_MAX, 20'd0);
		// sweeps on radio 0 after its beacon (empty, round end, empty), then an empty on radio 1
		send_word(FUNC_EMPTY, 1'b0, 48'h0, t, 20'd5);
		send_word(FUNC_ROUND_END, 1'b0, 48'h0, t, 20'd5);
		send_word(FUNC_EMPTY, 1'b0, 48'h0, t, 20'd5);
		send_word(FUNC_EMPTY, 1'b1, 48'h0, t, 20'd5);
		// fill radio 1 until full, for both listed and beacon words
		for (int i = 0; i < NB + 1; i++)
			send_word(FUNC_LISTED, 1'b1, 48'h800000000000 | ADDR_W'(i), 32'd10, 20'd3);
		send_word(FUNC_BEACON, 1'b1, 48'h7FFFFFFFFFFF, 32'd10, 20'd3);
	endtask

	task automatic test_config_extremes;
		write_reg(REG_COOLOFF, 20'd0);
		write_reg(REG_PEER_WAIT, 20'hFFFFF);
		write_reg(REG_SEND_WIFI, 20'd0);
		send_word(FUNC_BEACON, 1'b1, 48'h000000000001, 32'd5000, 20'd1);
		send_word(FUNC_LISTED, 1'b1, 48'h000000000001, 32'd5000, 20'd1);
		send_word(FUNC_BEACON, 1'b0, 48'h000000000002, 32'd5000, 20'd1);
		write_reg(REG_PEER_WAIT, 20'd0);
		send_word(FUNC_BEACON, 1'b0, 48'h000000000002, 32'd6000, 20'd1);
		send_word(FUNC_LISTED, 1'b0, 48'h000000000002, 32'd6001, 20'd1);
		send_word(FUNC_LISTED, 1'b0, 48'h000000000002, 32'd6001, 20'd1);
		write_reg(REG_COOLOFF, 20'hFFFFF);
		write_reg(REG_SEND_WIFI, 20'd1);
	endtask

	// a round of listed neighbours from a small pool per radio, with beacons, round ends and empties
	task automatic random_words(int n);
		logic [1:0] f;
		logic r;
		int roll;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			r = 1'($urandom_range(1));
			if (roll < 65) f = FUNC_LISTED;
			else if (roll < 85) f = FUNC_BEACON;
			else if (roll < 93) f = FUNC_ROUND_END;
			else f = FUNC_EMPTY;
			clock_now = clock_now + $urandom_range(60);
			if ($urandom_range(49) == 0) clock_now = clock_now - $urandom_range(200);
			send_word(f, r,
				($urandom_range(19) == 0) ? ADDR_W'({$urandom, $urandom}) :
				{r, 39'h0, 8'($urandom_range(11))} | 48'h3C0000000000,
				($urandom_range(99) == 0) ? T_MAX - $urandom_range(3) : clock_now,
				($urandom_range(9) == 0) ? TICK_W'($urandom) :
				TICK_W'($urandom_range(120)));
		end
	endtask

	task automatic test_random_phases;
		idle_pct = 0; stall_pct = 0;
		random_words(200);
		idle_pct = 67; stall_pct = 0;
		random_words(150);
		write_reg(REG_COOLOFF, TICK_W'($urandom_range(400)));
		write_reg(REG_PEER_WAIT, TICK_W'($urandom_range(150)));
		idle_pct = 0; stall_pct = 67;
		random_words(150);
		write_reg(REG_SEND_WIFI, 20'd0);
		idle_pct = 17; stall_pct = 17;
		random_words(150);
		write_reg(REG_COOLOFF, 20'd300);
		write_reg(REG_PEER_WAIT, 20'd100);
		write_reg(REG_SEND_WIFI, 20'd1);
		idle_pct = 0; stall_pct = 0;
	endtask

	task automatic test_backpressure;
		fork
			begin
				hold_off = 1'b1;
				repeat (2000) @(negedge clk);
				hold_off = 1'b0;
			end
			random_words(30);
		join
		// sender pauses until every word has come back
		drain();
		random_words(120);
	endtask

	initial begin
		m_cooloff = 20'd300;
		m_peer_wait = 20'd100;
		m_send_wifi = 1'b1;
		for (int k = 0; k < SLOTS; k++) begin
			m_valid[k] = 1'b0;
			m_addr[k] = '0;
			m_cool_end[k] = '0;
			m_seen[k] = 1'b0;
			clear_timers(k);
		end
		m_changed[0] = 1'b0;
		m_changed[1] = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_config_extremes();
		test_random_phases();
		test_backpressure();
		drain();
		$display("covered %0d words, %0d checked, %0d beacons, %0d table full",
			words_sent, words_checked, syncs_seen, fulls_seen);
		$display("all functions, both radios, register extremes and long output stalls");
		if (errors == 0 && pending_verdicts.size() == 0) begin
			$display("** neighbour_sync_backoff_table_unit: PASSED **");
		end else begin
			$display("** neighbour_sync_backoff_table_unit: FAILED **");
		end
		$finish;
	end
endmodule
